>>> rtl/cmb_pkg.sv
// Package for the combination enumerator: request, result and configuration types,
// register codes and fixed field widths. No dependencies.
package cmb_pkg;

    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned PADDR_W    = 3;
    localparam int unsigned SET_SIZE_W = 5;
    localparam int unsigned PICK_W     = 4;
    localparam int unsigned CHAR_W     = 8;
    localparam int unsigned SLOT_W     = 4;
    localparam int unsigned POS_W      = 3;
    localparam int unsigned SOL_W      = 14;
    localparam int unsigned TRIAL_W    = 32;

    localparam logic [SET_SIZE_W-1:0] SET_SIZE_RST = 5'd7;
    localparam logic [PICK_W-1:0]     PICK_RST     = 4'd4;
    localparam logic [SOL_W-1:0]      SOL_TOP      = '1;
    localparam logic [TRIAL_W-1:0]    TRIAL_TOP    = '1;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_NEXT = 1'b1
    } t_op;

    typedef enum logic {
        REG_SET_SIZE   = 1'b0,
        REG_PICK_COUNT = 1'b1
    } t_reg_idx;

    typedef struct packed {
        t_op               op;
        logic [SLOT_W-1:0] char_index;
        logic [CHAR_W-1:0] char_value;
    } t_req;

    typedef struct packed {
        logic [CHAR_W-1:0]  out_char;
        logic [SLOT_W-1:0]  element_index;
        logic [POS_W-1:0]   position;
        logic               last;
        logic               finished;
        logic [SOL_W-1:0]   solution_number;
        logic [TRIAL_W-1:0] trial_count;
    } t_res;

    typedef struct packed {
        logic [SET_SIZE_W-1:0] set_size;
        logic [PICK_W-1:0]     pick_count;
        logic                  restart;
    } t_cfg;

endpackage

>>> rtl/cmb_if.sv
// Valid/ready channel interfaces for requests and results of the combination enumerator.
// Depends on cmb_pkg for the payload types.
interface cmb_req_if;
    import cmb_pkg::*;
    logic valid;
    logic ready;
    t_req data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface cmb_res_if;
    import cmb_pkg::*;
    logic valid;
    logic ready;
    t_res data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> rtl/combination_enumerator.sv
// Top level of the combination enumerator: configuration registers and search sequencer.
// Depends on cmb_pkg, cmb_if, cmb_cfg and cmb_seq.
//
//   channel   direction  protocol       payload
//   i_req     in         valid/ready    op, char_index, char_value
//   o_res     out        valid/ready    out_char .. trial_count, one result per element
//   APB       in/out     psel/penable   set_size (0x0), pick_count (0x4)
//
// A load writes the character store. A next request enters the search step, which tries
// a candidate per visit and passes the floor state for each backtracked level, then an
// address state and a data state per emitted element, since the character store has a
// registered read port. Reset is synchronous and clears the index stack at once; there is
// no clearing pass. The result register lets the search proceed while a result waits;
// the sequencer holds when that register is still full.
module combination_enumerator #(
    parameter int unsigned MAX_SET  = 16,
    parameter int unsigned MAX_PICK = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    cmb_req_if.sink                        i_req,
    cmb_res_if.source                      o_res,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [cmb_pkg::PADDR_W-1:0]    paddr,
    input  logic [cmb_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [cmb_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready
);
    import cmb_pkg::*;

    t_cfg cfg;

    cmb_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    cmb_seq #(
        .MAX_SET  (MAX_SET),
        .MAX_PICK (MAX_PICK)
    ) u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_req   (i_req),
        .o_res   (o_res)
    );

endmodule

>>> rtl/cmb_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module cmb_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16,
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/cmb_cfg.sv
// APB-style configuration registers of the combination enumerator.
// Depends on cmb_pkg; hands the register values and a restart strobe to the sequencer.
module cmb_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [cmb_pkg::PADDR_W-1:0]      paddr,
    input  logic [cmb_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [cmb_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                             pready,
    output cmb_pkg::t_cfg                    o_cfg
);
    import cmb_pkg::*;

    logic [SET_SIZE_W-1:0] r_set_size;
    logic [PICK_W-1:0]     r_pick_count;
    logic                  wr_en;
    t_reg_idx              reg_idx;

    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = t_reg_idx'(paddr[2]);
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set_size   <= SET_SIZE_RST;
            r_pick_count <= PICK_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_SET_SIZE: begin
                    r_set_size <= pwdata[SET_SIZE_W-1:0];
                end
                REG_PICK_COUNT: begin
                    r_pick_count <= pwdata[PICK_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_SET_SIZE:   prdata = CFG_DATA_W'(r_set_size);
            REG_PICK_COUNT: prdata = CFG_DATA_W'(r_pick_count);
            default:        prdata = '0;
        endcase
    end

    // Any write restarts the search at the same edge that updates the registers.
    assign o_cfg.set_size   = r_set_size;
    assign o_cfg.pick_count = r_pick_count;
    assign o_cfg.restart    = wr_en;

endmodule

>>> rtl/cmb_seq.sv
// Search sequencer: index stack, shared compare/increment step, counters, character
// store and result register. Depends on cmb_pkg, cmb_if and cmb_ram.
module cmb_seq #(
    parameter int unsigned MAX_SET  = 16,
    parameter int unsigned MAX_PICK = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  cmb_pkg::t_cfg i_cfg,
    cmb_req_if.sink       i_req,
    cmb_res_if.source     o_res
);
    import cmb_pkg::*;

    localparam int unsigned SW = $clog2(MAX_SET + 1);
    localparam int unsigned AW = (MAX_SET > 1) ? $clog2(MAX_SET) : 1;
    localparam int unsigned DW = (MAX_PICK > 1) ? $clog2(MAX_PICK) : 1;
    localparam int unsigned KW = $clog2(MAX_PICK + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_FLOOR,
        S_EMIT_ADDR,
        S_EMIT_DATA,
        S_FIN
    } t_state;

    t_state             r_state, n_state;
    logic [SW-1:0]      r_stack [MAX_PICK];
    logic [DW-1:0]      r_depth, n_depth;
    logic [DW-1:0]      r_pos, n_pos;
    logic [SW-1:0]      r_floor, n_floor;
    logic               r_fresh, n_fresh;
    logic               r_done, n_done;
    logic [SOL_W-1:0]   r_sol, n_sol;
    logic [TRIAL_W-1:0] r_trial, n_trial;
    logic [AW-1:0]      r_idx, n_idx;
    logic               r_out_valid, n_out_valid;
    t_res               r_res, n_res;

    logic [SW-1:0]      tam;
    logic [KW-1:0]      k;
    logic [DW-1:0]      k_m1;
    logic [DW-1:0]      rd_ptr;
    logic [SW-1:0]      rd_val;
    logic [SW-1:0]      cand;
    logic               stack_we;
    logic [SW-1:0]      stack_wval;
    logic               out_free;
    logic               load_out;
    logic               req_fire;
    logic               ram_we;
    logic               ram_re;
    logic [AW-1:0]      ram_raddr;
    logic [CHAR_W-1:0]  ram_rdata;

    always_comb begin
        if (32'(i_cfg.set_size) > MAX_SET) begin
            tam = SW'(MAX_SET);
        end else begin
            tam = SW'(i_cfg.set_size);
        end
        if (i_cfg.pick_count == '0) begin
            k = KW'(1);
        end else if (32'(i_cfg.pick_count) > MAX_PICK) begin
            k = KW'(MAX_PICK);
        end else begin
            k = KW'(i_cfg.pick_count);
        end
        k_m1 = DW'(k - 1'b1);
    end

    assign rd_val    = r_stack[rd_ptr];
    assign cand      = r_fresh ? '0 : rd_val;
    assign out_free  = !r_out_valid || o_res.ready;
    assign req_fire  = i_req.valid && i_req.ready;
    assign ram_we    = req_fire && (i_req.data.op == OP_LOAD)
                       && (32'(i_req.data.char_index) < MAX_SET);
    assign ram_raddr = AW'(rd_val - 1'b1);

    cmb_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (MAX_SET)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (AW'(i_req.data.char_index)),
        .i_wdata (i_req.data.char_value),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state     = r_state;
        n_depth     = r_depth;
        n_pos       = r_pos;
        n_floor     = r_floor;
        n_fresh     = r_fresh;
        n_done      = r_done;
        n_sol       = r_sol;
        n_trial     = r_trial;
        n_idx       = r_idx;
        n_res       = r_res;
        n_out_valid = r_out_valid;
        rd_ptr      = r_depth;
        stack_we    = 1'b0;
        stack_wval  = cand + 1'b1;
        ram_re      = 1'b0;
        load_out    = 1'b0;

        if (r_out_valid && o_res.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (req_fire && (i_req.data.op == OP_NEXT)) begin
                    n_state = r_done ? S_FIN : S_SEARCH;
                end
            end
            S_SEARCH: begin
                if (cand >= tam) begin
                    n_fresh = 1'b0;
                    if (r_depth == '0) begin
                        n_done  = 1'b1;
                        n_state = S_FIN;
                    end else begin
                        n_depth = r_depth - 1'b1;
                        n_state = S_FLOOR;
                    end
                end else begin
                    stack_we = 1'b1;
                    n_fresh  = 1'b0;
                    if (r_trial != TRIAL_TOP) begin
                        n_trial = r_trial + 1'b1;
                    end
                    if (cand >= r_floor) begin
                        if (r_depth == k_m1) begin
                            if (r_sol != SOL_TOP) begin
                                n_sol = r_sol + 1'b1;
                            end
                            n_pos   = '0;
                            n_state = S_EMIT_ADDR;
                        end else begin
                            n_depth = r_depth + 1'b1;
                            n_floor = cand + 1'b1;
                            n_fresh = 1'b1;
                        end
                    end
                end
            end
            S_FLOOR: begin
                rd_ptr  = r_depth - 1'b1;
                n_floor = (r_depth == '0) ? '0 : rd_val;
                n_state = S_SEARCH;
            end
            S_EMIT_ADDR: begin
                rd_ptr  = r_pos;
                ram_re  = 1'b1;
                n_idx   = ram_raddr;
                n_state = S_EMIT_DATA;
            end
            S_EMIT_DATA: begin
                if (out_free) begin
                    load_out              = 1'b1;
                    n_out_valid           = 1'b1;
                    n_res.out_char        = ram_rdata;
                    n_res.element_index   = SLOT_W'(r_idx);
                    n_res.position        = POS_W'(r_pos);
                    n_res.last            = (r_pos == k_m1);
                    n_res.finished        = 1'b0;
                    n_res.solution_number = r_sol;
                    n_res.trial_count     = r_trial;
                    if (r_pos == k_m1) begin
                        n_state = S_IDLE;
                    end else begin
                        n_pos   = r_pos + 1'b1;
                        n_state = S_EMIT_ADDR;
                    end
                end
            end
            S_FIN: begin
                if (out_free) begin
                    load_out              = 1'b1;
                    n_out_valid           = 1'b1;
                    n_res.out_char        = '0;
                    n_res.element_index   = '0;
                    n_res.position        = '0;
                    n_res.last            = 1'b1;
                    n_res.finished        = 1'b1;
                    n_res.solution_number = r_sol;
                    n_res.trial_count     = r_trial;
                    n_state               = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_depth     <= '0;
            r_pos       <= '0;
            r_floor     <= '0;
            r_fresh     <= 1'b0;
            r_done      <= 1'b0;
            r_sol       <= '0;
            r_trial     <= '0;
            r_out_valid <= 1'b0;
            r_idx       <= '0;
            r_res       <= '0;
            for (int i = 0; i < MAX_PICK; i++) begin
                r_stack[i] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_pos       <= n_pos;
            r_out_valid <= n_out_valid;
            r_idx       <= n_idx;
            r_res       <= n_res;
            if (i_cfg.restart) begin
                r_depth <= '0;
                r_floor <= '0;
                r_fresh <= 1'b0;
                r_done  <= 1'b0;
                r_sol   <= '0;
                r_trial <= '0;
                for (int i = 0; i < MAX_PICK; i++) begin
                    r_stack[i] <= '0;
                end
            end else begin
                r_depth <= n_depth;
                r_floor <= n_floor;
                r_fresh <= n_fresh;
                r_done  <= n_done;
                r_sol   <= n_sol;
                r_trial <= n_trial;
                if (stack_we) begin
                    r_stack[r_depth] <= stack_wval;
                end
            end
        end
    end

    assign i_req.ready = (r_state == S_IDLE);
    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_res;

    a_depth_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= k_m1)
        else $error("search depth beyond the last level");

    a_trial_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cfg.restart |=> r_trial >= $past(r_trial))
        else $error("trial counter went backwards without a restart");

    a_no_result_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out |-> (!r_out_valid || o_res.ready))
        else $error("result register overwritten while still pending");

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for combination_enumerator: directed table then random phases.
// Depends on cmb_pkg, cmb_if and the RTL; an internal predictor supplies the expected results.
`timescale 1ns / 1ps

module tb_top;
    import cmb_pkg::*;

    localparam int unsigned N_RANDOM   = 480;
    localparam int unsigned SLOTS      = 16;
    localparam int unsigned LEVELS     = 8;

    typedef struct {
        bit          is_cfg;
        t_reg_idx    rg;
        logic [31:0] wdata;
        t_req        req;
        bit          typed;
        t_res        exp;
    } t_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [PADDR_W-1:0]    paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    cmb_req_if req_ch ();
    cmb_res_if res_ch ();

    combination_enumerator u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_res   (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #4 i_clk = ~i_clk;

    // Predictor state of the enumerator.
    logic [CHAR_W-1:0]     char_mem [SLOTS];
    logic [4:0]            idx_stack [LEVELS];
    int unsigned           lvl;
    bit                    exhausted;
    logic [SOL_W-1:0]      sol_cnt;
    logic [TRIAL_W-1:0]    trial_cnt;
    logic [SET_SIZE_W-1:0] set_sz;
    logic [PICK_W-1:0]     pick_n;

    t_res  due_elements [$];
    t_row  directed_rows [$];
    int    n_errors = 0;
    bit    req_no_gap = 1'b0;
    bit    res_no_stall = 1'b0;

    function automatic void clear_search();
        foreach (idx_stack[i]) idx_stack[i] = '0;
        lvl       = 0;
        exhausted = 1'b0;
        sol_cnt   = '0;
        trial_cnt = '0;
    endfunction

    function automatic void apply_register(t_reg_idx rg, logic [31:0] v);
        if (rg == REG_SET_SIZE) set_sz = v[SET_SIZE_W-1:0];
        else pick_n = v[PICK_W-1:0];
        clear_search();
    endfunction

    // Stores a load; a next request resumes the depth-first search and queues the elements of
    // the next combination, or one finished answer once exhausted, or a typed row's result.
    function automatic void step_enumerator(t_req r, bit typed, t_res typed_res);
        int   tam;
        int   k;
        int   d;
        int   c;
        int   x;
        int   ix;
        bit   found;
        bit   ok;
        t_res e;
        if (r.op == OP_LOAD) begin
            char_mem[r.char_index] = r.char_value;
            return;
        end
        tam   = (set_sz > SLOTS) ? SLOTS : set_sz;
        k     = (pick_n == 0) ? 1 : ((pick_n > LEVELS) ? LEVELS : pick_n);
        found = 1'b0;
        if (!exhausted) begin
            d = (lvl >= k) ? k - 1 : lvl;
            while (!exhausted && !found) begin
                c = int'(idx_stack[d]);
                if (c >= tam) begin
                    if (d == 0) begin
                        lvl       = 0;
                        exhausted = 1'b1;
                    end else begin
                        d--;
                    end
                end else begin
                    if (trial_cnt != TRIAL_TOP) trial_cnt++;
                    idx_stack[d] = 5'(c + 1);
                    ok = 1'b1;
                    for (x = 0; x < d; x++) if (c < idx_stack[x]) ok = 1'b0;
                    if (ok) begin
                        if (d + 1 >= k) begin
                            lvl   = d;
                            found = 1'b1;
                        end else begin
                            d++;
                            idx_stack[d] = '0;
                        end
                    end
                end
            end
        end
        if (found && sol_cnt != SOL_TOP) sol_cnt++;
        if (typed) begin
            due_elements.push_back(typed_res);
        end else if (found) begin
            for (x = 0; x < k; x++) begin
                ix                = idx_stack[x] - 1;
                e.out_char        = char_mem[ix];
                e.element_index   = ix[SLOT_W-1:0];
                e.position        = x[POS_W-1:0];
                e.last            = (x + 1 == k);
                e.finished        = 1'b0;
                e.solution_number = sol_cnt;
                e.trial_count     = trial_cnt;
                due_elements.push_back(e);
            end
        end else begin
            e                 = '0;
            e.last            = 1'b1;
            e.finished        = 1'b1;
            e.solution_number = sol_cnt;
            e.trial_count     = trial_cnt;
            due_elements.push_back(e);
        end
    endfunction

    function automatic void add_row(bit is_cfg, t_reg_idx rg, logic [31:0] v, t_op op,
                                    logic [SLOT_W-1:0] ix, logic [CHAR_W-1:0] cv,
                                    bit typed, logic [SOL_W-1:0] sol, logic [TRIAL_W-1:0] tr);
        t_row row;
        row.is_cfg = is_cfg;
        row.rg     = rg;
        row.wdata  = v;
        row.req    = '{op: op, char_index: ix, char_value: cv};
        row.typed  = typed;
        row.exp    = '{out_char: '0, element_index: '0, position: '0, last: 1'b1,
                       finished: 1'b1, solution_number: sol, trial_count: tr};
        directed_rows.push_back(row);
    endfunction

    task automatic check_field(string name, longint unsigned exp_v, longint unsigned act_v);
        if (exp_v != act_v) begin
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
            n_errors++;
        end
    endtask

    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (due_elements.size() == 0) begin
                $display("%0t ns: unexpected result, expected none, got %p",
                         $time, res_ch.data);
                n_errors++;
            end else begin
                want = due_elements.pop_front();
                check_field("out_char", want.out_char, res_ch.data.out_char);
                check_field("element_index", want.element_index, res_ch.data.element_index);
                check_field("position", want.position, res_ch.data.position);
                check_field("last", want.last, res_ch.data.last);
                check_field("finished", want.finished, res_ch.data.finished);
                check_field("solution_number", want.solution_number,
                            res_ch.data.solution_number);
                check_field("trial_count", want.trial_count, res_ch.data.trial_count);
            end
        end
    end

    initial begin
        res_ch.ready = 1'b0;
        forever begin
            int gap;
            gap = res_no_stall ? 0 : $urandom_range(0, 10);
            repeat (gap) begin
                @(negedge i_clk);
                res_ch.ready <= 1'b0;
            end
            @(negedge i_clk);
            res_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!(res_ch.valid && res_ch.ready));
        end
    end

    task automatic send_request(t_req r, bit typed, t_res typed_res);
        int gap;
        gap = req_no_gap ? 0 : $urandom_range(0, 10);
        repeat (gap) begin
            @(negedge i_clk);
            req_ch.valid <= 1'b0;
        end
        @(negedge i_clk);
        req_ch.valid <= 1'b1;
        req_ch.data  <= r;
        do @(posedge i_clk); while (!(req_ch.valid && req_ch.ready));
        step_enumerator(r, typed, typed_res);
    endtask

    task automatic wait_idle(int settle);
        @(negedge i_clk);
        req_ch.valid <= 1'b0;
        do @(posedge i_clk); while (due_elements.size() != 0);
        repeat (settle) @(posedge i_clk);
    endtask

    // Register write followed by a read back of the same register.
    task automatic cfg_write(t_reg_idx rg, logic [31:0] v);
        logic [31:0] want;
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {rg, 2'b00};
        pwdata  <= v;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        apply_register(rg, v);
        want = (rg == REG_SET_SIZE) ? 32'(set_sz) : 32'(pick_n);
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== want) begin
            $display("%0t ns: register %s read back, expected %0d, got %0d",
                     $time, rg.name(), want, prdata);
            n_errors++;
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    initial begin
        t_req        r;
        int          n_sent;
        int          batch;
        int          mode;
        logic [31:0] s_val;
        logic [31:0] p_val;

        i_rst_n      = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        req_ch.valid = 1'b0;
        req_ch.data  = '0;
        set_sz       = SET_SIZE_RST;
        pick_n       = PICK_RST;
        clear_search();

        for (int i = 0; i < SLOTS; i++) begin
            add_row(0, REG_SET_SIZE, 0, OP_LOAD, i[3:0],
                    (i == 0) ? 8'h00 : (i == 1) ? 8'hFF :
                    (i < 10) ? 8'(1 << (i - 2)) : ~8'(1 << (i - 10)), 0, 0, 0);
        end
        add_row(0, REG_SET_SIZE, 0, OP_NEXT, 4'hF, 8'hFF, 0, 0, 0);
        add_row(0, REG_SET_SIZE, 0, OP_NEXT, 4'h0, 8'h00, 0, 0, 0);
        // An empty set exhausts the search at once, and stays exhausted.
        add_row(1, REG_SET_SIZE, 0, OP_NEXT, 0, 0, 0, 0, 0);
        add_row(0, REG_SET_SIZE, 0, OP_NEXT, 4'h5, 8'hA5, 1, 0, 0);
        add_row(0, REG_SET_SIZE, 0, OP_NEXT, 4'hA, 8'h5A, 1, 0, 0);
        // More picks than slots: every trial is spent, then the search is finished.
        add_row(1, REG_SET_SIZE, 1, OP_NEXT, 0, 0, 0, 0, 0);
        add_row(1, REG_PICK_COUNT, 2, OP_NEXT, 0, 0, 0, 0, 0);
        add_row(0, REG_SET_SIZE, 0, OP_NEXT, 0, 0, 1, 0, 2);
        // A pick count of zero behaves as one.
        add_row(1, REG_PICK_COUNT, 0, OP_NEXT, 0, 0, 0, 0, 0);
        add_row(0, REG_SET_SIZE, 0, OP_NEXT, 0, 0, 0, 0, 0);
        add_row(0, REG_SET_SIZE, 0, OP_NEXT, 0, 0, 1, 1, 1);
        // Values above the limits are clamped; a load mid-search leaves the search alone.
        add_row(1, REG_SET_SIZE, 32'hFFFF_FFFF, OP_NEXT, 0, 0, 0, 0, 0);
        add_row(1, REG_PICK_COUNT, 32'hFFFF_FFFF, OP_NEXT, 0, 0, 0, 0, 0);
        add_row(0, REG_SET_SIZE, 0, OP_NEXT, 0, 0, 0, 0, 0);
        add_row(0, REG_SET_SIZE, 0, OP_LOAD, 4'h3, 8'h3C, 0, 0, 0);
        add_row(0, REG_SET_SIZE, 0, OP_NEXT, 0, 0, 0, 0, 0);

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            if (directed_rows[i].is_cfg) begin
                wait_idle(20);
                cfg_write(directed_rows[i].rg, directed_rows[i].wdata);
            end else begin
                send_request(directed_rows[i].req, directed_rows[i].typed,
                             directed_rows[i].exp);
            end
        end

        n_sent = 0;
        while (n_sent < N_RANDOM) begin
            wait_idle(20);
            mode = $urandom_range(0, 9);
            case (mode)
                0: begin
                    s_val = 16;
                    p_val = 8;
                end
                1: begin
                    s_val = $urandom_range(17, 31);
                    p_val = $urandom_range(9, 15);
                end
                2: begin
                    s_val = 0;
                    p_val = $urandom_range(0, 15);
                end
                3: begin
                    s_val = $urandom_range(1, 5);
                    p_val = $urandom_range(s_val + 1, 8);
                end
                4, 5, 6: begin
                    s_val = $urandom_range(1, 7);
                    p_val = $urandom_range(0, s_val);
                end
                default: begin
                    s_val = $urandom_range(1, 16);
                    p_val = $urandom_range(1, 8);
                end
            endcase
            s_val[31:SET_SIZE_W] = (32 - SET_SIZE_W)'($urandom());
            p_val[31:PICK_W]     = (32 - PICK_W)'($urandom());
            if ($urandom_range(0, 1)) begin
                cfg_write(REG_SET_SIZE, s_val);
                cfg_write(REG_PICK_COUNT, p_val);
            end else begin
                cfg_write(REG_PICK_COUNT, p_val);
                cfg_write(REG_SET_SIZE, s_val);
            end
            req_no_gap   = ($urandom_range(0, 3) == 0);
            res_no_stall = ($urandom_range(0, 3) == 0);
            batch = $urandom_range(8, 40);
            repeat (batch) begin
                r.op         = ($urandom_range(0, 99) < 80) ? OP_NEXT : OP_LOAD;
                r.char_index = SLOT_W'($urandom_range(0, 15));
                r.char_value = CHAR_W'($urandom_range(0, 255));
                send_request(r, 1'b0, '0);
                n_sent++;
            end
        end

        req_no_gap   = 1'b0;
        res_no_stall = 1'b0;
        wait_idle(100);
        if (n_errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
